// ----- rtl/core/rgb_hls_color_converter_macros.svh -----
// Assertion helpers shared by the converter RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef RGB_HLS_COLOR_CONVERTER_MACROS_SVH
`define RGB_HLS_COLOR_CONVERTER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RHC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define RHC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rhc_pkg.sv -----
package rhc_pkg;

    // Operation codes.
    localparam logic [1:0] OP_RGB2HLS = 2'd0;
    localparam logic [1:0] OP_HLS2RGB = 2'd1;
    localparam logic [1:0] OP_DESAT   = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Hue is in 1/64 degree, luminance and saturation in Q1.12.
    localparam logic [14:0] HUE_FULL   = 15'd23040;
    localparam logic [14:0] SIXTH_TURN = 15'd3840;
    localparam logic [12:0] ONE_Q12    = 13'd4096;
    localparam logic [12:0] HALF_Q12   = 13'd2048;

    // floor(2^28 / 255), used to divide the luminance sum by 255.
    localparam logic [20:0] LUM_RECIP = 21'd1052688;

    // Pipelined divider geometry: the quotient is known to fit in DIV_QUO_W bits.
    localparam int unsigned DIV_DEN_W  = 8;
    localparam int unsigned DIV_QUO_W  = 16;
    localparam int unsigned DIV_NUM_W  = DIV_DEN_W + DIV_QUO_W;
    localparam int unsigned DIV_STEPS  = 4;
    localparam int unsigned DIV_STAGES = DIV_QUO_W / DIV_STEPS;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [14:0] hue;
        logic [12:0] lum;
        logic [12:0] sat;
    } t_pix;

endpackage

// ----- rtl/core/rhc_div.sv -----
module rhc_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rhc_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [rhc_pkg::DIV_DEN_W-1:0] i_den,
    output logic [rhc_pkg::DIV_QUO_W-1:0] o_quo
);

    localparam int unsigned NW     = rhc_pkg::DIV_NUM_W;
    localparam int unsigned DW     = rhc_pkg::DIV_DEN_W;
    localparam int unsigned QW     = rhc_pkg::DIV_QUO_W;
    localparam int unsigned STEPS  = rhc_pkg::DIV_STEPS;
    localparam int unsigned STAGES = rhc_pkg::DIV_STAGES;

    logic [DW-1:0] r_rem [STAGES-1];
    logic [QW-1:0] r_low [STAGES-1];
    logic [DW-1:0] r_den [STAGES-1];
    logic [QW-1:0] r_quo [STAGES];

    // Restoring division, STEPS quotient bits per stage. The top DW bits of the
    // dividend are already below the divisor because the quotient fits in QW bits.
    for (genvar gs = 0; gs < STAGES; gs++) begin : g_stage
        logic [DW-1:0] w_rem_in;
        logic [QW-1:0] w_low_in;
        logic [QW-1:0] w_quo_in;
        logic [DW-1:0] w_den;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_low;
        logic [QW-1:0] n_quo;
        logic [DW:0]   w_trial;

        if (gs == 0) begin : g_first
            assign w_rem_in = i_num[NW-1:QW];
            assign w_low_in = i_num[QW-1:0];
            assign w_quo_in = '0;
            assign w_den    = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[gs-1];
            assign w_low_in = r_low[gs-1];
            assign w_quo_in = r_quo[gs-1];
            assign w_den    = r_den[gs-1];
        end

        always_comb begin
            n_rem   = w_rem_in;
            n_low   = w_low_in;
            n_quo   = w_quo_in;
            w_trial = '0;
            for (int j = 0; j < STEPS; j++) begin
                w_trial = {n_rem, n_low[QW-1]};
                n_low   = {n_low[QW-2:0], 1'b0};
                if (w_trial >= {1'b0, w_den}) begin
                    n_rem = DW'(w_trial - {1'b0, w_den});
                    n_quo = {n_quo[QW-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[DW-1:0];
                    n_quo = {n_quo[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[gs] <= n_quo;
            end
        end

        if (gs < STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[gs] <= n_rem;
                    r_low[gs] <= n_low;
                    r_den[gs] <= w_den;
                end
            end
        end
    end

    assign o_quo = r_quo[STAGES-1];

endmodule

// ----- rtl/core/rhc_fwd.sv -----
module rhc_fwd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic [14:0] o_hue,
    output logic [12:0] o_lum,
    output logic [12:0] o_sat
);

    localparam logic [1:0] MAX_RED   = 2'd0;
    localparam logic [1:0] MAX_GREEN = 2'd1;
    localparam logic [1:0] MAX_BLUE  = 2'd2;
    localparam int unsigned TAIL     = rhc_pkg::DIV_STAGES;

    // Stage A: extremes and which channel holds the maximum.
    logic [7:0]        n_a_max, n_a_min;
    logic [1:0]        n_a_sel;
    logic signed [8:0] n_a_diff;
    logic              n_a_wrap;
    logic [7:0]        r_a_max, r_a_min;
    logic [1:0]        r_a_sel;
    logic signed [8:0] r_a_diff;
    logic              r_a_wrap;

    always_comb begin
        n_a_max = i_red;
        n_a_min = i_red;
        if (i_green > n_a_max) n_a_max = i_green;
        if (i_blue > n_a_max)  n_a_max = i_blue;
        if (i_green < n_a_min) n_a_min = i_green;
        if (i_blue < n_a_min)  n_a_min = i_blue;
        n_a_wrap = 1'b0;
        // Blue wins ties over green, green over red.
        priority if (i_blue == n_a_max) begin
            n_a_sel  = MAX_BLUE;
            n_a_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end else if (i_green == n_a_max) begin
            n_a_sel  = MAX_GREEN;
            n_a_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_a_sel  = MAX_RED;
            n_a_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            n_a_wrap = i_green > i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_max  <= n_a_max;
            r_a_min  <= n_a_min;
            r_a_sel  <= n_a_sel;
            r_a_diff <= n_a_diff;
            r_a_wrap <= n_a_wrap;
        end
    end

    // Stage B: chroma, sum, saturation divisor and hue numerator in sixths.
    logic [7:0]         w_b_d;
    logic [8:0]         w_b_sum;
    logic [8:0]         w_b_alt;
    logic [10:0]        w_b_kd;
    logic signed [11:0] w_b_v;
    logic [7:0]         r_b_d;
    logic [8:0]         r_b_sum;
    logic [7:0]         r_b_den;
    logic [10:0]        r_b_v;
    logic               r_b_wrap;

    assign w_b_d   = r_a_max - r_a_min;
    assign w_b_sum = {1'b0, r_a_max} + {1'b0, r_a_min};
    assign w_b_alt = 9'd510 - w_b_sum;

    always_comb begin
        unique case (r_a_sel)
            MAX_BLUE:  w_b_kd = {1'b0, w_b_d, 2'b00};
            MAX_GREEN: w_b_kd = {2'b00, w_b_d, 1'b0};
            default:   w_b_kd = {1'b0, w_b_d, 2'b00} + {2'b00, w_b_d, 1'b0};
        endcase
        w_b_v = $signed({1'b0, w_b_kd}) + $signed({{3{r_a_diff[8]}}, r_a_diff});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_d    <= w_b_d;
            r_b_sum  <= w_b_sum;
            r_b_den  <= (w_b_sum <= 9'd255) ? w_b_sum[7:0] : w_b_alt[7:0];
            r_b_v    <= w_b_v[10:0];
            r_b_wrap <= r_a_wrap;
        end
    end

    // Stage C: scale numerators, start the luminance reciprocal product.
    logic [23:0] r_c_hnum;
    logic [23:0] r_c_snum;
    logic [7:0]  r_c_d;
    logic [7:0]  r_c_den;
    logic [29:0] r_c_lp;
    logic [8:0]  r_c_sum;
    logic        r_c_dz;
    logic        r_c_wrap;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_hnum <= {1'b0, r_b_v, 12'd0} - {5'd0, r_b_v, 8'd0};
            r_c_snum <= {4'd0, r_b_d, 12'd0};
            r_c_d    <= r_b_d;
            r_c_den  <= r_b_den;
            r_c_lp   <= 30'(r_b_sum) * 30'(rhc_pkg::LUM_RECIP);
            r_c_sum  <= r_b_sum;
            r_c_dz   <= (r_b_d == 8'd0);
            r_c_wrap <= r_b_wrap;
        end
    end

    logic [15:0] w_hue_quo;
    logic [15:0] w_sat_quo;

    rhc_div u_div_hue (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_c_hnum),
        .i_den (r_c_d),
        .o_quo (w_hue_quo)
    );

    rhc_div u_div_sat (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_c_snum),
        .i_den (r_c_den),
        .o_quo (w_sat_quo)
    );

    // Luminance: the reciprocal estimate is at most one low, fixed by one compare.
    logic [19:0] w_d1_x;
    logic [12:0] w_d1_q0;
    logic [20:0] w_d1_q255;
    logic [20:0] w_d1_rem;
    logic [12:0] r_d1_q0;
    logic [9:0]  r_d1_rem;
    logic [12:0] r_lum [TAIL-1];
    logic        r_dz [TAIL];
    logic        r_wrap [TAIL];

    assign w_d1_x    = {r_c_sum, 11'd0};
    assign w_d1_q0   = r_c_lp[29:17];
    assign w_d1_q255 = {w_d1_q0, 8'd0} - {8'd0, w_d1_q0};
    assign w_d1_rem  = {1'b0, w_d1_x} - w_d1_q255;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1_q0   <= w_d1_q0;
            r_d1_rem  <= w_d1_rem[9:0];
            r_lum[0]  <= (r_d1_rem >= 10'd255) ? r_d1_q0 + 13'd1 : r_d1_q0;
            r_dz[0]   <= r_c_dz;
            r_wrap[0] <= r_c_wrap;
            for (int k = 1; k < TAIL - 1; k++) begin
                r_lum[k] <= r_lum[k-1];
            end
            for (int k = 1; k < TAIL; k++) begin
                r_dz[k]   <= r_dz[k-1];
                r_wrap[k] <= r_wrap[k-1];
            end
        end
    end

    logic [15:0] w_hue_adj;

    // A red maximum with green above blue lands one full turn high.
    assign w_hue_adj = w_hue_quo - {1'b0, rhc_pkg::HUE_FULL};
    assign o_hue = r_dz[TAIL-1]   ? '0 :
                   r_wrap[TAIL-1] ? w_hue_adj[14:0] : w_hue_quo[14:0];
    assign o_sat = r_dz[TAIL-1] ? '0 : w_sat_quo[12:0];
    assign o_lum = r_lum[TAIL-2];

endmodule

// ----- rtl/core/rhc_inv.sv -----
module rhc_inv (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [14:0] i_hue,
    input  logic [12:0] i_lum,
    input  logic [12:0] i_sat,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    localparam logic [14:0] TWO_SIXTH   = rhc_pkg::SIXTH_TURN * 15'd2;
    localparam logic [14:0] THREE_SIXTH = rhc_pkg::SIXTH_TURN * 15'd3;
    localparam logic [14:0] FOUR_SIXTH  = rhc_pkg::SIXTH_TURN * 15'd4;
    localparam int unsigned CH          = 3;

    // Position on the ramp between the low and high level, in 1/64 degree.
    function automatic logic [11:0] ramp_pos(input logic [14:0] x);
        logic [14:0] w_fall;
        w_fall = FOUR_SIXTH - x;
        priority if (x < rhc_pkg::SIXTH_TURN) ramp_pos = x[11:0];
        else if (x < THREE_SIXTH)             ramp_pos = rhc_pkg::SIXTH_TURN[11:0];
        else if (x < FOUR_SIXTH)              ramp_pos = w_fall[11:0];
        else                                  ramp_pos = 12'd0;
    endfunction

    // P1: l*s product and the three channel hues.
    logic [15:0] w_rh_sum;
    logic [15:0] w_rh_wrap;
    logic [25:0] w_ls;
    logic [24:0] r_p1_ls;
    logic [12:0] r_p1_lum;
    logic [12:0] r_p1_sat;
    logic        r_p1_low;
    logic [14:0] r_p1_h [CH];

    assign w_rh_sum  = {1'b0, i_hue} + {1'b0, TWO_SIXTH};
    assign w_rh_wrap = w_rh_sum - {1'b0, rhc_pkg::HUE_FULL};
    assign w_ls      = 26'(i_lum) * 26'(i_sat);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_ls   <= w_ls[24:0];
            r_p1_lum  <= i_lum;
            r_p1_sat  <= i_sat;
            r_p1_low  <= (i_lum <= rhc_pkg::HALF_Q12);
            r_p1_h[0] <= (w_rh_sum > {1'b0, rhc_pkg::HUE_FULL}) ? w_rh_wrap[14:0]
                                                               : w_rh_sum[14:0];
            r_p1_h[1] <= i_hue;
            r_p1_h[2] <= (i_hue < TWO_SIXTH) ? i_hue + FOUR_SIXTH : i_hue - TWO_SIXTH;
        end
    end

    // P2: low level m1 and swing m2 - m1, both Q24.
    logic [25:0] w_l24;
    logic [25:0] w_s24;
    logic [25:0] w_m1;
    logic [25:0] w_diff;
    logic [24:0] r_p2_m1;
    logic [24:0] r_p2_diff;
    logic [11:0] r_p2_t [CH];

    assign w_l24 = {1'b0, r_p1_lum, 12'd0};
    assign w_s24 = {1'b0, r_p1_sat, 12'd0};

    always_comb begin
        if (r_p1_low) begin
            w_m1   = w_l24 - {1'b0, r_p1_ls};
            w_diff = {r_p1_ls, 1'b0};
        end else begin
            w_m1   = w_l24 + {1'b0, r_p1_ls} - w_s24;
            w_diff = {w_s24[24:0] - r_p1_ls, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2_m1   <= w_m1[24:0];
            r_p2_diff <= w_diff[24:0];
            for (int c = 0; c < CH; c++) begin
                r_p2_t[c] <= ramp_pos(r_p1_h[c]);
            end
        end
    end

    // P3 to P5: num = m1*3840 + swing*pos, then channel = num*255/(3840*2^24),
    // which reduces to num*17 >> 32.
    logic [36:0] r_p3_m1c;
    logic [36:0] r_p3_prod [CH];
    logic [36:0] r_p4_num [CH];
    logic [40:0] w_p5_scaled [CH];
    logic [7:0]  r_p5_rgb [CH];
    logic [7:0]  r_p6_rgb [CH];
    logic [7:0]  r_p7_rgb [CH];

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_p5_scaled[c] = {4'd0, r_p4_num[c]} + {r_p4_num[c], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p3_m1c <= {r_p2_m1, 12'd0} - {4'd0, r_p2_m1, 8'd0};
            for (int c = 0; c < CH; c++) begin
                r_p3_prod[c] <= 37'(r_p2_diff) * 37'(r_p2_t[c]);
                r_p4_num[c]  <= r_p3_m1c + r_p3_prod[c];
                r_p5_rgb[c]  <= w_p5_scaled[c][39:32];
                r_p6_rgb[c]  <= r_p5_rgb[c];
                r_p7_rgb[c]  <= r_p6_rgb[c];
            end
        end
    end

    assign o_red   = r_p7_rgb[0];
    assign o_green = r_p7_rgb[1];
    assign o_blue  = r_p7_rgb[2];

endmodule

// ----- rtl/core/rgb_hls_color_converter.sv -----
// Channel  Handshake          Beat contents
// -------  -----------------  ------------------------------------------------
// input    i_valid / o_ready  i_op, i_red_in, i_green_in, i_blue_in,
//                             i_hue_in, i_lum_in, i_sat_in
// output   o_valid / i_ready  o_red_out, o_green_out, o_blue_out,
//                             o_hue_out, o_lum_out, o_sat_out
//
// One beat is accepted every cycle unless the output stalls; its result is offered
// at the end of 9 register stages.
// The depth is set by the two 16-bit quotient dividers (4 quotient bits a stage).
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stall on the output freezes every stage at once; o_ready follows
// (!o_valid || i_ready), so no beat is dropped or repeated.
`include "rgb_hls_color_converter_macros.svh"

module rgb_hls_color_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [14:0] i_hue_in,
    input  logic [12:0] i_lum_in,
    input  logic [12:0] i_sat_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [14:0] o_hue_out,
    output logic [12:0] o_lum_out,
    output logic [12:0] o_sat_out
);

    localparam int unsigned DEPTH      = 9;
    localparam int unsigned ECHO_DEPTH = 7;

    logic [DEPTH-1:0] r_vld;
    logic             w_adv;
    logic [12:0]      w_gray_sum;
    logic [7:0]       w_gray;
    rhc_pkg::t_pix    n_pix;
    rhc_pkg::t_pix    r_pix;
    rhc_pkg::t_pix    r_echo [ECHO_DEPTH];
    rhc_pkg::t_pix    w_echo;
    rhc_pkg::t_pix    n_out;
    rhc_pkg::t_pix    r_out;
    logic [14:0]      w_fwd_hue;
    logic [12:0]      w_fwd_lum;
    logic [12:0]      w_fwd_sat;
    logic [7:0]       w_inv_red;
    logic [7:0]       w_inv_green;
    logic [7:0]       w_inv_blue;

    assign w_adv   = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[DEPTH-1];

    // Weighted gray (11r + 16g + 5b) / 32.
    assign w_gray_sum = ({5'd0, i_red_in} * 13'd11) + {1'b0, i_green_in, 4'd0}
                      + ({5'd0, i_blue_in} * 13'd5);
    assign w_gray     = w_gray_sum[12:5];

    always_comb begin
        n_pix.op = i_op;
        if (i_op == rhc_pkg::OP_DESAT) begin
            n_pix.red   = w_gray;
            n_pix.green = w_gray;
            n_pix.blue  = w_gray;
        end else begin
            n_pix.red   = i_red_in;
            n_pix.green = i_green_in;
            n_pix.blue  = i_blue_in;
        end
        n_pix.hue = (i_hue_in > rhc_pkg::HUE_FULL) ? i_hue_in - rhc_pkg::HUE_FULL : i_hue_in;
        n_pix.lum = (i_lum_in > rhc_pkg::ONE_Q12) ? rhc_pkg::ONE_Q12 : i_lum_in;
        n_pix.sat = (i_sat_in > rhc_pkg::ONE_Q12) ? rhc_pkg::ONE_Q12 : i_sat_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pix     <= n_pix;
            r_echo[0] <= r_pix;
            for (int k = 1; k < ECHO_DEPTH; k++) begin
                r_echo[k] <= r_echo[k-1];
            end
            r_out <= n_out;
        end
    end

    rhc_fwd u_fwd (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_red   (r_pix.red),
        .i_green (r_pix.green),
        .i_blue  (r_pix.blue),
        .o_hue   (w_fwd_hue),
        .o_lum   (w_fwd_lum),
        .o_sat   (w_fwd_sat)
    );

    rhc_inv u_inv (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_hue   (r_pix.hue),
        .i_lum   (r_pix.lum),
        .i_sat   (r_pix.sat),
        .o_red   (w_inv_red),
        .o_green (w_inv_green),
        .o_blue  (w_inv_blue)
    );

    assign w_echo = r_echo[ECHO_DEPTH-1];

    always_comb begin
        n_out = w_echo;
        unique case (w_echo.op)
            rhc_pkg::OP_RGB2HLS, rhc_pkg::OP_DESAT: begin
                n_out.hue = w_fwd_hue;
                n_out.lum = w_fwd_lum;
                n_out.sat = w_fwd_sat;
            end
            rhc_pkg::OP_HLS2RGB: begin
                n_out.red   = w_inv_red;
                n_out.green = w_inv_green;
                n_out.blue  = w_inv_blue;
            end
            rhc_pkg::OP_NONE: begin
                n_out    = '0;
                n_out.op = w_echo.op;
            end
        endcase
    end

    assign o_red_out   = r_out.red;
    assign o_green_out = r_out.green;
    assign o_blue_out  = r_out.blue;
    assign o_hue_out   = r_out.hue;
    assign o_lum_out   = r_out.lum;
    assign o_sat_out   = r_out.sat;

    `RHC_ASSERT_IMP(a_ready_when_free, 1'b1, o_ready == (!o_valid || i_ready), "ready does not follow the output stage")
    `RHC_ASSERT_NXT(a_stall_keeps_beat, r_vld[DEPTH-2] && !w_adv, r_vld[DEPTH-2], "a stalled beat left the pipeline")
    `RHC_ASSERT_IMP(a_gray_no_chroma, o_valid && (r_out.op != rhc_pkg::OP_HLS2RGB) && (o_red_out == o_green_out) && (o_green_out == o_blue_out), (o_hue_out == 15'd0) && (o_sat_out == 13'd0), "gray pixel with nonzero hue or saturation")
    `RHC_ASSERT_IMP(a_result_range, o_valid, (o_hue_out <= rhc_pkg::HUE_FULL) && (o_lum_out <= rhc_pkg::ONE_Q12) && (o_sat_out <= rhc_pkg::ONE_Q12), "result out of range")

endmodule
